@@ sv/crcfr_pkg.sv @@
package crcfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] CRC_POLY  = 8'h1D;
  localparam logic [7:0] CRC_INIT  = 8'hFF;

  localparam logic [7:0] ID_JOINT  = 8'h10;
  localparam logic [7:0] ID_FORCE  = 8'h11;
  localparam logic [7:0] ID_ACK    = 8'h12;
  localparam logic [7:0] ID_MODE   = 8'h20;

  localparam logic [10:0] REC_SIZE_JOINT = 11'd5;
  localparam logic [10:0] REC_SIZE_FORCE = 11'd3;
  localparam logic [7:0]  RESULT_CAP     = 8'd31;

  typedef enum logic [1:0] {
    KIND_JOINT  = 2'd0,
    KIND_FORCE  = 2'd1,
    KIND_ACK    = 2'd2,
    KIND_INTENT = 2'd3
  } kind_e;

  typedef struct packed {
    logic       bank;
    kind_e      kind;
    logic [4:0] count;
    logic [7:0] lo;
    logic [7:0] hi;
  } job_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [6:0] idx;
    logic [7:0] data;
  } wr_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] v;
    v = c ^ d;
    for (int b = 0; b < 8; b++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

@@ sv/crcfr_front.sv @@
module crcfr_front import crcfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 96
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic [6:0] max_len_i,
  input  logic [7:0] mode_code_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o,
  output wr_t        wr_o
);

  localparam logic [1:0] ST_SYNC    = 2'd0;
  localparam logic [1:0] ST_HEADER  = 2'd1;
  localparam logic [1:0] ST_PAYLOAD = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  logic [1:0] state_q;
  logic [1:0] hdr_q;
  logic [7:0] msg_q;
  logic [6:0] len_q;
  logic [6:0] idx_q;
  logic [7:0] crc_q;
  logic [7:0] b0_q;
  logic [7:0] b1_q;
  logic       bank_q;

  logic        accept;
  logic        too_long;
  logic [6:0]  idx_nxt;
  logic [10:0] need;
  logic        rec_ok;
  logic        ok;
  kind_e       kind;
  logic [4:0]  count;

  assign in_ready_o = !(((state_q == ST_PAYLOAD) || (state_q == ST_CRC)) && q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign too_long   = (rx_byte_i > {1'b0, max_len_i}) || (32'(rx_byte_i) > MAX_PAYLOAD);
  assign idx_nxt    = idx_q + 7'd1;

  // classify the finished frame
  assign need   = 11'(b0_q) * ((msg_q == ID_JOINT) ? REC_SIZE_JOINT : REC_SIZE_FORCE) + 11'd1;
  assign rec_ok = (len_q != 7'd0) && (b0_q != 8'd0) && (need <= 11'(len_q));
  assign count  = (b0_q > RESULT_CAP) ? 5'(RESULT_CAP) : b0_q[4:0];

  always_comb begin
    ok   = 1'b0;
    kind = KIND_JOINT;
    unique case (msg_q)
      ID_JOINT: begin
        ok   = rec_ok;
        kind = KIND_JOINT;
      end
      ID_FORCE: begin
        ok   = rec_ok;
        kind = KIND_FORCE;
      end
      ID_ACK: begin
        ok   = (len_q >= 7'd2);
        kind = KIND_ACK;
      end
      ID_MODE: begin
        ok   = (len_q >= 7'd2) && (b0_q == mode_code_i);
        kind = KIND_INTENT;
      end
      default: begin
        ok   = 1'b0;
        kind = KIND_JOINT;
      end
    endcase
  end

  assign push_o      = accept && (state_q == ST_CRC) && (rx_byte_i == crc_q) && ok;
  assign job_o.bank  = bank_q;
  assign job_o.kind  = kind;
  assign job_o.count = count;
  assign job_o.lo    = b0_q;
  assign job_o.hi    = b1_q;

  assign wr_o.en   = accept && (state_q == ST_PAYLOAD);
  assign wr_o.bank = bank_q;
  assign wr_o.idx  = idx_q;
  assign wr_o.data = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC;
      hdr_q   <= 2'd0;
      msg_q   <= 8'd0;
      len_q   <= 7'd0;
      idx_q   <= 7'd0;
      crc_q   <= CRC_INIT;
      b0_q    <= 8'd0;
      b1_q    <= 8'd0;
      bank_q  <= 1'b0;
    end else if (accept) begin
      unique case (state_q)
        ST_SYNC: begin
          if (rx_byte_i == SYNC_BYTE) begin
            state_q <= ST_HEADER;
            hdr_q   <= 2'd0;
            crc_q   <= CRC_INIT;
          end
        end
        ST_HEADER: begin
          crc_q <= crc8_byte(crc_q, rx_byte_i);
          case (hdr_q)
            2'd0: hdr_q <= 2'd1;
            2'd1: begin
              msg_q <= rx_byte_i;
              hdr_q <= 2'd2;
            end
            default: begin
              hdr_q <= 2'd0;
              idx_q <= 7'd0;
              if (too_long) begin
                state_q <= ST_SYNC;
                len_q   <= 7'd0;
              end else begin
                len_q   <= rx_byte_i[6:0];
                state_q <= (rx_byte_i == 8'd0) ? ST_CRC : ST_PAYLOAD;
              end
            end
          endcase
        end
        ST_PAYLOAD: begin
          crc_q <= crc8_byte(crc_q, rx_byte_i);
          if (idx_q == 7'd0) b0_q <= rx_byte_i;
          if (idx_q == 7'd1) b1_q <= rx_byte_i;
          if (idx_nxt >= len_q) begin
            state_q <= ST_CRC;
            idx_q   <= 7'd0;
          end else begin
            idx_q <= idx_nxt;
          end
        end
        default: begin
          state_q <= ST_SYNC;
          hdr_q   <= 2'd0;
          idx_q   <= 7'd0;
          len_q   <= 7'd0;
          if (push_o) bank_q <= ~bank_q;
        end
      endcase
    end
  end

endmodule

@@ sv/crcfr_queue.sv @@
module crcfr_queue import crcfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  job_t       mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ sv/crcfr_back.sv @@
module crcfr_back import crcfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 96
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wr_t                wr_i,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         motor_id_o,
  output logic signed [15:0] position_q15_o,
  output logic signed [15:0] velocity_q15_o,
  output logic [15:0]        force_millinewton_o,
  output logic [15:0]        ack_value_o,
  output logic [7:0]         intent_id_o,
  output logic               last_o
);

  localparam int unsigned DEPTH = 2 * MAX_PAYLOAD;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_CAPT = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  logic [1:0] st_q;
  logic [6:0] idx_q;
  logic [2:0] k_q;
  logic [4:0] left_q;
  logic [7:0] rec_q [5];

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  motor_q;
  logic [15:0] pos_q;
  logic [15:0] vel_q;
  logic [15:0] force_q;
  logic [15:0] ack_q;
  logic [7:0]  intent_q;
  logic        last_q;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          simple;
  logic          is_joint;
  logic          is_force;
  logic [2:0]    k_last;
  logic          out_free;
  logic          load;
  logic          fin;

  assign rd_addr  = (job_i.bank ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(idx_q);
  assign wr_addr  = (wr_i.bank ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(wr_i.idx);
  assign is_joint = (job_i.kind == KIND_JOINT);
  assign is_force = (job_i.kind == KIND_FORCE);
  assign simple   = !is_joint && !is_force;
  assign k_last   = is_joint ? 3'd4 : 3'd2;
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = (st_q == B_EMIT) && out_free;
  assign fin      = simple || (left_q == 5'd1);
  assign pop_o    = load && fin;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_addr] <= wr_i.data;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      idx_q  <= 7'd0;
      k_q    <= 3'd0;
      left_q <= 5'd0;
    end else begin
      unique case (st_q)
        B_IDLE: begin
          if (job_valid_i) begin
            idx_q  <= 7'd1;
            k_q    <= 3'd0;
            left_q <= job_i.count;
            st_q   <= simple ? B_EMIT : B_READ;
          end
        end
        B_READ: st_q <= B_CAPT;
        B_CAPT: begin
          idx_q <= idx_q + 7'd1;
          if (k_q == k_last) begin
            st_q <= B_EMIT;
          end else begin
            k_q  <= k_q + 3'd1;
            st_q <= B_READ;
          end
        end
        default: begin
          if (load) begin
            k_q <= 3'd0;
            if (fin) begin
              st_q <= B_IDLE;
            end else begin
              left_q <= left_q - 5'd1;
              st_q   <= B_READ;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_CAPT) rec_q[k_q] <= rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= job_i.kind;
      motor_q  <= simple ? 8'd0 : rec_q[0];
      pos_q    <= is_joint ? {rec_q[2], rec_q[1]} : 16'd0;
      vel_q    <= is_joint ? {rec_q[4], rec_q[3]} : 16'd0;
      force_q  <= is_force ? {rec_q[2], rec_q[1]} : 16'd0;
      ack_q    <= (job_i.kind == KIND_ACK) ? {job_i.hi, job_i.lo} : 16'd0;
      intent_q <= (job_i.kind == KIND_INTENT) ? job_i.hi : 8'd0;
      last_q   <= fin;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign motor_id_o          = motor_q;
  assign position_q15_o      = pos_q;
  assign velocity_q15_o      = vel_q;
  assign force_millinewton_o = force_q;
  assign ack_value_o         = ack_q;
  assign intent_id_o         = intent_q;
  assign last_o              = last_q;

endmodule

@@ sv/crc8_frame_receiver_decoder.sv @@
// One received byte is taken per cycle while the queue to the record unit has room.
// Ack and intent frames go from the queue to the output register without a payload
// RAM read; joint records read five payload bytes and force records three, each byte
// read and captured before the output register loads. Up to two decoded frames overlap.
// Reset clears the parser, queue and output valid; payload RAM contents stay undefined.
module crc8_frame_receiver_decoder import crcfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 96
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         motor_id_o,
  output logic signed [15:0] position_q15_o,
  output logic signed [15:0] velocity_q15_o,
  output logic [15:0]        force_millinewton_o,
  output logic [15:0]        ack_value_o,
  output logic [7:0]         intent_id_o,
  output logic               last_o
);

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_MODE    = 1'b1;

  logic [6:0] max_len_q;
  logic [7:0] mode_q;
  logic       cfg_wr;

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t job_in;
  job_t job_head;
  wr_t  wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 7'd96;
      mode_q    <= 8'd8;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_LEN: max_len_q <= pwdata[6:0];
        REG_MODE:    mode_q    <= pwdata[7:0];
        default:     mode_q    <= mode_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MODE) ? {24'd0, mode_q} : {25'd0, max_len_q};

  crcfr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .max_len_i  (max_len_q),
    .mode_code_i(mode_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in),
    .wr_o       (wr)
  );

  crcfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (job_head)
  );

  crcfr_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .wr_i               (wr),
    .job_valid_i        (q_valid),
    .job_i              (job_head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .motor_id_o         (motor_id_o),
    .position_q15_o     (position_q15_o),
    .velocity_q15_o     (velocity_q15_o),
    .force_millinewton_o(force_millinewton_o),
    .ack_value_o        (ack_value_o),
    .intent_id_o        (intent_id_o),
    .last_o             (last_o)
  );

endmodule
